// ===== hw/rtl/lifo_stack_with_swap_top_assert.svh =====
// ----------------------------------------------------------------------------
// lifo stack with swap: assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SWAP_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_SWAP_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define LSWS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define LSWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LSWS_ASSERT(label, clk, rst_n, prop, msg)

`define LSWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/lsws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsws_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lsws_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 4;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int CMP_W      = (FILL_W > POS_W) ? FILL_W : POS_W;

    localparam logic [FILL_W-1:0]        FILL_FULL    = FILL_W'(DEPTH);
    localparam logic signed [DATA_W-1:0] DATA_NEG_ONE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 3'd0,
        FUNC_POP  = 3'd1,
        FUNC_PEEK = 3'd2,
        FUNC_SWAP = 3'd3,
        FUNC_DUMP = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_POS  = 3'd3,
        ST_SAME_POS = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_NEG_ONE,
        SEL_RD_A
    } t_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESULT,
        S_SWAP_A,
        S_SWAP_B,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    rd_swap;
        logic    push;
        logic    pop;
        logic    dump_step;
        logic    swap_wr_a;
        logic    swap_wr_b;
        logic    out_load;
        t_sel    out_sel;
        t_status out_status;
        logic    out_last;
        logic    out_pos_en;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_zero;
        logic fill_full;
        logic same_pos;
        logic bad_pos;
        logic dump_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/lsws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsws_ctrl
// operation sequencer: decodes each beat and steps the datapath
// ----------------------------------------------------------------------------
module lsws_ctrl import lsws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_status        i_dp_status,
    output logic              o_ready,
    output t_dp_cmd           o_dp_cmd
);

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;
    t_sel    r_res_sel, n_res_sel;

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_sel    = r_res_sel;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        FUNC_PUSH: begin
                            n_state      = S_RESULT;
                            n_res_sel    = SEL_ZERO;
                            n_res_status = i_dp_status.fill_full ? ST_FULL : ST_OK;
                        end
                        FUNC_POP, FUNC_PEEK: begin
                            n_state      = S_RESULT;
                            n_res_sel    = i_dp_status.fill_zero ? SEL_NEG_ONE : SEL_RD_A;
                            n_res_status = i_dp_status.fill_zero ? ST_EMPTY : ST_OK;
                        end
                        FUNC_SWAP: begin
                            n_res_sel = SEL_ZERO;
                            if (i_dp_status.same_pos) begin
                                n_state      = S_RESULT;
                                n_res_status = ST_SAME_POS;
                            end else if (i_dp_status.bad_pos) begin
                                n_state      = S_RESULT;
                                n_res_status = ST_BAD_POS;
                            end else begin
                                n_state      = S_SWAP_A;
                                n_res_status = ST_OK;
                            end
                        end
                        FUNC_DUMP: begin
                            if (i_dp_status.fill_zero) begin
                                n_state      = S_RESULT;
                                n_res_sel    = SEL_NEG_ONE;
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SWAP_A: begin
                n_state = S_SWAP_B;
            end
            S_SWAP_B: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_dp_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_dp_status.out_free && i_dp_status.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        o_dp_cmd = '{
            accept:     1'b0,
            rd_swap:    1'b0,
            push:       1'b0,
            pop:        1'b0,
            dump_step:  1'b0,
            swap_wr_a:  1'b0,
            swap_wr_b:  1'b0,
            out_load:   1'b0,
            out_sel:    SEL_ZERO,
            out_status: ST_OK,
            out_last:   1'b0,
            out_pos_en: 1'b0
        };
        case (r_state)
            S_IDLE: begin
                o_ready          = 1'b1;
                o_dp_cmd.accept  = i_valid;
                o_dp_cmd.rd_swap = (i_func == FUNC_SWAP);
                o_dp_cmd.push    = i_valid && (i_func == FUNC_PUSH)
                                   && !i_dp_status.fill_full;
                o_dp_cmd.pop     = i_valid && (i_func == FUNC_POP)
                                   && !i_dp_status.fill_zero;
            end
            S_SWAP_A: begin
                o_dp_cmd.swap_wr_a = 1'b1;
            end
            S_SWAP_B: begin
                o_dp_cmd.swap_wr_b = 1'b1;
            end
            S_RESULT: begin
                o_dp_cmd.out_load   = i_dp_status.out_free;
                o_dp_cmd.out_sel    = r_res_sel;
                o_dp_cmd.out_status = r_res_status;
                o_dp_cmd.out_last   = 1'b1;
            end
            S_DUMP: begin
                o_dp_cmd.out_load   = i_dp_status.out_free;
                o_dp_cmd.out_sel    = SEL_RD_A;
                o_dp_cmd.out_status = ST_OK;
                o_dp_cmd.out_last   = i_dp_status.dump_last;
                o_dp_cmd.out_pos_en = 1'b1;
                o_dp_cmd.dump_step  = i_dp_status.out_free && !i_dp_status.dump_last;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_OK;
            r_res_sel    <= SEL_ZERO;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_res_sel    <= n_res_sel;
        end
    end

endmodule

// ===== hw/rtl/lsws_dpath.sv =====
`timescale 1ns / 1ps
`include "lifo_stack_with_swap_top_assert.svh"
// ----------------------------------------------------------------------------
// lsws_dpath
// entry memory, fill counter, position checks and result register
// ----------------------------------------------------------------------------
module lsws_dpath import lsws_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [POS_W-1:0]         i_first_position,
    input  logic [POS_W-1:0]         i_second_position,
    input  logic                     i_ready,
    output t_dp_status               o_dp_status,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_data_word,
    output logic [POS_W-1:0]         o_entry_position,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_is_empty,
    output logic                     o_last
);

    logic signed [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic signed [WORD_WIDTH-1:0] r_rd_a, r_rd_b;
    logic [ADDR_W-1:0]            r_addr_a, r_addr_b;
    logic [FILL_W-1:0]            r_fill, n_fill;
    logic [ADDR_W-1:0]            r_dpos;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    logic [POS_W-1:0]         r_out_pos;
    t_status                  r_out_status;
    logic                     r_out_empty;
    logic                     r_out_last;

    logic [POS_W-1:0]             pos_a;
    logic [FILL_W-1:0]            top_index;
    logic [ADDR_W-1:0]            rd_addr_a, rd_addr_b;
    logic                         rd_en;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic signed [WORD_WIDTH-1:0] wr_data;
    logic signed [DATA_W-1:0]     out_data;
    logic                         out_free;
    logic                         dump_last;

    assign pos_a     = i_cmd.rd_swap ? i_first_position : '0;
    assign top_index = r_fill - FILL_W'(1);
    assign rd_addr_a = i_cmd.dump_step ? (r_addr_a - ADDR_W'(1))
                                       : ADDR_W'(top_index - FILL_W'(pos_a));
    assign rd_addr_b = ADDR_W'(top_index - FILL_W'(i_second_position));
    assign rd_en     = i_cmd.accept || i_cmd.dump_step;
    assign out_free  = !r_out_valid || i_ready;
    assign dump_last = (FILL_W'(r_dpos) + FILL_W'(1)) == r_fill;

    always_comb begin
        wr_en   = i_cmd.push || i_cmd.swap_wr_a || i_cmd.swap_wr_b;
        wr_addr = ADDR_W'(r_fill);
        wr_data = WORD_WIDTH'(i_push_value);
        if (i_cmd.swap_wr_a) begin
            wr_addr = r_addr_a;
            wr_data = r_rd_b;
        end else if (i_cmd.swap_wr_b) begin
            wr_addr = r_addr_b;
            wr_data = r_rd_a;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.push) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_cmd.pop) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            SEL_ZERO:    out_data = '0;
            SEL_NEG_ONE: out_data = DATA_NEG_ONE;
            SEL_RD_A:    out_data = DATA_W'(r_rd_a);
            default:     out_data = '0;
        endcase
    end

    always_comb begin
        o_dp_status.fill_zero = (r_fill == '0);
        o_dp_status.fill_full = (r_fill == FILL_FULL);
        o_dp_status.same_pos  = (i_first_position == i_second_position);
        o_dp_status.bad_pos   = (CMP_W'(i_first_position) >= CMP_W'(r_fill))
                                || (CMP_W'(i_second_position) >= CMP_W'(r_fill));
        o_dp_status.dump_last = dump_last;
        o_dp_status.out_free  = out_free;
    end

    // entry memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a   <= r_mem[rd_addr_a];
            r_rd_b   <= r_mem[rd_addr_b];
            r_addr_a <= rd_addr_a;
            r_addr_b <= rd_addr_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dpos <= '0;
        end else if (i_cmd.dump_step) begin
            r_dpos <= r_dpos + ADDR_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_data   <= out_data;
            r_out_pos    <= i_cmd.out_pos_en ? POS_W'(r_dpos) : '0;
            r_out_status <= i_cmd.out_status;
            r_out_empty  <= (r_fill == '0);
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_data_word      = r_out_data;
    assign o_entry_position = r_out_pos;
    assign o_status         = r_out_status;
    assign o_is_empty       = r_out_empty;
    assign o_last           = r_out_last;

    `LSWS_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_FULL, "fill count beyond depth")
    `LSWS_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_cmd.push, r_fill != FILL_FULL, "push while full")
    `LSWS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_cmd.pop, r_fill != '0, "pop while empty")
    `LSWS_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, out_free, "result beat overwritten")

endmodule

// ===== hw/rtl/lifo_stack_with_swap_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_swap_top
// bounded lifo stack of signed words with push, pop, peek, swap and dump
// ----------------------------------------------------------------------------
// One operation is worked on at a time; the input is ready only while the
// sequencer is idle. The entries live in a 16-word memory with one write port
// and two registered read ports; push, pop and peek go from accept to the
// result state, and swap reads both entries, then writes them back one per
// cycle in S_SWAP_A and S_SWAP_B through the single write port. Dump streams
// one beat per cycle while the receiver takes them, top first. An empty dump,
// a full push or a rejected swap goes straight to the result state; an unused
// code gives no result beat. The result register lets the sequencer finish
// while the last beat waits; a stalled result beat holds it until taken.
module lifo_stack_with_swap_top import lsws_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [POS_W-1:0]         i_first_position,
    input  logic [POS_W-1:0]         i_second_position,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_data_word,
    output logic [POS_W-1:0]         o_entry_position,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_is_empty,
    output logic                     o_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    lsws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_dp_status (dp_status),
        .o_ready     (o_ready),
        .o_dp_cmd    (dp_cmd)
    );

    lsws_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_push_value      (i_push_value),
        .i_first_position  (i_first_position),
        .i_second_position (i_second_position),
        .i_ready           (i_ready),
        .o_dp_status       (dp_status),
        .o_valid           (o_valid),
        .o_data_word       (o_data_word),
        .o_entry_position  (o_entry_position),
        .o_status          (o_status),
        .o_is_empty        (o_is_empty),
        .o_last            (o_last)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for lifo_stack_with_swap_top
// drives push, pop, peek, swap, dump and unused codes through the input
// handshake, first from a directed table, then as random runs that grow and
// shrink the stack. each beat taken is checked field by field against one
// predicted by an in-bench stack model or given by the directed table row.
// sender gaps and receiver stalls are varied from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
    import lsws_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
    localparam int PHASE_ITEMS   = 28;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         pos;
        logic [STATUS_W-1:0]      status;
        logic                     is_empty;
        logic                     last;
    } beat_t;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         p1;
        logic [POS_W-1:0]         p2;
        int                       rep;
        bit                       typed;
        beat_t                    want;
    } op_row_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [FUNC_W-1:0]        i_func = '0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic [POS_W-1:0]         i_first_position = '0;
    logic [POS_W-1:0]         i_second_position = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_data_word;
    logic [POS_W-1:0]         o_entry_position;
    logic [STATUS_W-1:0]      o_status;
    logic                     o_is_empty;
    logic                     o_last;

    lifo_stack_with_swap_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_push_value      (i_push_value),
        .i_first_position  (i_first_position),
        .i_second_position (i_second_position),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_data_word       (o_data_word),
        .o_entry_position  (o_entry_position),
        .o_status          (o_status),
        .o_is_empty        (o_is_empty),
        .o_last            (o_last)
    );

    logic signed [DATA_W-1:0] stack_words [DEPTH];
    int                       stack_fill = 0;
    beat_t                    beats_due [$];
    op_row_t                  op_table [$];
    int                       mismatch_count = 0;
    int                       send_idle_pct = 0;
    int                       recv_stall_pct = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL lifo_stack_with_swap_top");
        $finish;
    end

    function automatic void apply_stack_op(input logic [FUNC_W-1:0] func,
                                           input logic signed [DATA_W-1:0] value,
                                           input logic [POS_W-1:0] p1,
                                           input logic [POS_W-1:0] p2,
                                           input bit keep);
        beat_t                    b;
        logic signed [DATA_W-1:0] t;
        int                       a;
        int                       c;
        b = '0;
        b.last = 1'b1;
        case (func)
            FUNC_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    b.status = ST_FULL;
                end else begin
                    stack_words[stack_fill] = value;
                    stack_fill++;
                    b.status = ST_OK;
                end
            end
            FUNC_POP: begin
                if (stack_fill == 0) begin
                    b.data = DATA_NEG_ONE;
                    b.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    b.data = stack_words[stack_fill];
                    b.status = ST_OK;
                end
            end
            FUNC_PEEK: begin
                if (stack_fill == 0) begin
                    b.data = DATA_NEG_ONE;
                    b.status = ST_EMPTY;
                end else begin
                    b.data = stack_words[stack_fill - 1];
                    b.status = ST_OK;
                end
            end
            FUNC_SWAP: begin
                if (p1 == p2) begin
                    b.status = ST_SAME_POS;
                end else if (int'(p1) >= stack_fill || int'(p2) >= stack_fill) begin
                    b.status = ST_BAD_POS;
                end else begin
                    a = stack_fill - 1 - int'(p1);
                    c = stack_fill - 1 - int'(p2);
                    t = stack_words[a];
                    stack_words[a] = stack_words[c];
                    stack_words[c] = t;
                    b.status = ST_OK;
                end
            end
            FUNC_DUMP: begin
                if (stack_fill == 0) begin
                    b.data = DATA_NEG_ONE;
                    b.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < stack_fill; i++) begin
                        b.data = stack_words[stack_fill - 1 - i];
                        b.pos = POS_W'(i);
                        b.status = ST_OK;
                        b.is_empty = 1'b0;
                        b.last = (i == stack_fill - 1);
                        if (keep) beats_due.push_back(b);
                    end
                    return;
                end
            end
            default: return;
        endcase
        b.is_empty = (stack_fill == 0);
        if (keep) beats_due.push_back(b);
    endfunction

    function automatic op_row_t mk_row(input logic [FUNC_W-1:0] func,
                                       input logic signed [DATA_W-1:0] value,
                                       input logic [POS_W-1:0] p1,
                                       input logic [POS_W-1:0] p2,
                                       input int rep,
                                       input bit typed,
                                       input logic signed [DATA_W-1:0] data,
                                       input logic [STATUS_W-1:0] status,
                                       input logic is_empty);
        op_row_t r;
        r.func = func;
        r.value = value;
        r.p1 = p1;
        r.p2 = p2;
        r.rep = rep;
        r.typed = typed;
        r.want = '{data: data, pos: '0, status: status, is_empty: is_empty, last: 1'b1};
        return r;
    endfunction

    task automatic drive_op(input logic [FUNC_W-1:0] func,
                            input logic signed [DATA_W-1:0] value,
                            input logic [POS_W-1:0] p1,
                            input logic [POS_W-1:0] p2,
                            input bit keep);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_push_value <= value;
        i_first_position <= p1;
        i_second_position <= p2;
        do @(posedge i_clk); while (!o_ready);
        apply_stack_op(func, value, p1, p2, keep);
    endtask

    task automatic random_op(input bit grow, output bit counted);
        int                       w;
        int                       r;
        logic [FUNC_W-1:0]        f;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         a;
        logic [POS_W-1:0]         c;
        w = $urandom_range(99);
        v = $urandom;
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
                0: v = 32'sh0000_0000;
                1: v = 32'shffff_ffff;
                2: v = 32'sh7fff_ffff;
                default: v = 32'sh8000_0000;
            endcase
        end
        a = POS_W'($urandom);
        c = POS_W'($urandom);
        if (w < 4) f = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        else if (w < (grow ? 54 : 24)) f = FUNC_PUSH;
        else if (w < (grow ? 64 : 59)) f = FUNC_POP;
        else if (w < 72) f = FUNC_PEEK;
        else if (w < 90) f = FUNC_SWAP;
        else f = FUNC_DUMP;
        if (f == FUNC_SWAP) begin
            r = $urandom_range(9);
            if (r < 8 && stack_fill >= 2) begin
                a = POS_W'($urandom_range(stack_fill - 1));
                do c = POS_W'($urandom_range(stack_fill - 1)); while (c == a);
            end else if (r == 8) begin
                c = a;
            end
        end
        counted = (f <= FUNC_DUMP);
        drive_op(f, v, a, c, 1'b1);
    endtask

    always @(posedge i_clk) begin
        beat_t got;
        beat_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{data: o_data_word, pos: o_entry_position, status: o_status,
                    is_empty: o_is_empty, last: o_last};
            if (beats_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: data %h pos %0d status %0d empty %b last %b",
                             got.data, got.pos, got.status, got.is_empty, got.last);
            end else begin
                want = beats_due.pop_front();
                if (got.data !== want.data || got.pos !== want.pos
                        || got.status !== want.status || got.is_empty !== want.is_empty
                        || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: exp data %h pos %0d status %0d empty %b last %b,",
                                 want.data, want.pos, want.status, want.is_empty, want.last,
                                 " got data %h pos %0d status %0d empty %b last %b",
                                 got.data, got.pos, got.status, got.is_empty, got.last);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int phase_send [4];
        int phase_recv [4];
        int done_ops;
        bit counted;
        phase_send = '{0, 56, 0, 20};
        phase_recv = '{0, 0, 56, 20};

        op_table.push_back(mk_row(FUNC_POP, 0, 0, 0, 1, 1, DATA_NEG_ONE, ST_EMPTY, 1));
        op_table.push_back(mk_row(FUNC_PEEK, 0, 0, 0, 1, 1, DATA_NEG_ONE, ST_EMPTY, 1));
        op_table.push_back(mk_row(FUNC_DUMP, 0, 0, 0, 1, 1, DATA_NEG_ONE, ST_EMPTY, 1));
        op_table.push_back(mk_row(FUNC_SWAP, 0, 0, 0, 1, 1, 0, ST_SAME_POS, 1));
        op_table.push_back(mk_row(FUNC_SWAP, 0, 0, 1, 1, 1, 0, ST_BAD_POS, 1));
        op_table.push_back(mk_row(FUNC_UNUSED_LO, 32'sh1234_5678, 3, 9, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PUSH, 32'sh7fff_ffff, 0, 0, 1, 1, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PUSH, 32'sh8000_0000, 0, 0, 1, 1, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PUSH, 32'shffff_ffff, 0, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PUSH, 32'sh0000_0000, 0, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_SWAP, 0, 0, 3, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_DUMP, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_SWAP, 0, 15, 15, 1, 1, 0, ST_SAME_POS, 0));
        op_table.push_back(mk_row(FUNC_SWAP, 0, 1, 15, 1, 1, 0, ST_BAD_POS, 0));
        op_table.push_back(mk_row(FUNC_POP, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PUSH, 32'sh5a5a_0000, 0, 0, 13, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PUSH, 32'sh0bad_cafe, 0, 0, 1, 1, 0, ST_FULL, 0));
        op_table.push_back(mk_row(FUNC_SWAP, 0, 15, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_DUMP, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_UNUSED_HI, 32'shffff_ffff, 15, 15, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_PEEK, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_POP, 0, 0, 0, 16, 0, 0, ST_OK, 0));
        op_table.push_back(mk_row(FUNC_POP, 0, 0, 0, 1, 1, DATA_NEG_ONE, ST_EMPTY, 1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (op_table[r]) begin
            for (int k = 0; k < op_table[r].rep; k++) begin
                drive_op(op_table[r].func, op_table[r].value + k, op_table[r].p1,
                         op_table[r].p2, !op_table[r].typed);
                if (op_table[r].typed) beats_due.push_back(op_table[r].want);
            end
        end

        for (int p = 0; p < 4; p++) begin
            // hold the sender until every pending beat is back
            i_valid <= 1'b0;
            do @(posedge i_clk); while (beats_due.size() != 0);
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            done_ops = 0;
            while (done_ops < PHASE_ITEMS) begin
                random_op(((done_ops / 12) % 2) == 0, counted);
                if (counted) done_ops++;
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (beats_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && beats_due.size() == 0) begin
            $display("PASS lifo_stack_with_swap_top");
        end else begin
            $display("FAIL lifo_stack_with_swap_top");
        end
        $finish;
    end

endmodule
